### sv/lifo_stack_with_replace_top_defines.svh
// ---------------------------------------------------------------------------
// LIFO stack assertion macros
// Concurrent assertion helpers for the LIFO stack; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_REPLACE_TOP_DEFINES_SVH
`define LIFO_STACK_WITH_REPLACE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define LSR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("LIFO stack assertion failed");
`define LSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("LIFO stack assertion failed");
`else
`define LSR_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### sv/lsr_pkg.sv
// ---------------------------------------------------------------------------
// LIFO stack package
// Sizes, command codes and status codes shared by the stack and its channels.
// ---------------------------------------------------------------------------
package lsr_pkg;

   localparam int DEPTH      = 16;
   localparam int ITEM_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_PUSH    = 2'd0,
      CMD_POP     = 2'd1,
      CMD_TOP     = 2'd2,
      CMD_REPLACE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   typedef logic [ITEM_WIDTH-1:0] item_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [ADDR_W-1:0]     addr_type;

endpackage

### sv/lsr_if.sv
// ---------------------------------------------------------------------------
// LIFO stack channels
// Valid/ready channels for command beats and result beats.
// ---------------------------------------------------------------------------
interface lsr_req_if;
   logic                 valid;
   logic                 ready;
   lsr_pkg::cmd_type     cmd;
   lsr_pkg::item_type    value;
   lsr_pkg::item_type    new_value;

   modport source (output valid, cmd, value, new_value, input ready);
   modport sink   (input valid, cmd, value, new_value, output ready);
endinterface

interface lsr_rsp_if;
   logic                 valid;
   logic                 ready;
   lsr_pkg::status_type  status;
   lsr_pkg::item_type    top_value;
   lsr_pkg::count_type   fill_count;
   logic                 is_empty;

   modport source (output valid, status, top_value, fill_count, is_empty, input ready);
   modport sink   (input valid, status, top_value, fill_count, is_empty, output ready);
endinterface

### sv/lifo_stack_with_replace_top.sv
// Push, read top, errors, replace when empty and a pop to empty give their result in the cycle
// after acceptance; the next command is taken in that cycle if the result is accepted, so one
// per cycle unless the result stalls. A pop leaving entries reads the new top into rdata_ff and
// S_POP registers it. A replace reads, compares and writes back one stored entry per cycle.
// Reset clears the fill count and control state; the memory is not cleared.
// ---------------------------------------------------------------------------
// LIFO stack with replace
// Bounded stack held in a synchronous memory, with a registered top entry and
// an entry-by-entry read-modify-write sweep for the replace command.
// ---------------------------------------------------------------------------
`include "lifo_stack_with_replace_top_defines.svh"

module lifo_stack_with_replace_top (
   input  logic      clock,
   input  logic      reset,
   lsr_req_if.sink   req_chan,
   lsr_rsp_if.source rsp_chan
);
   import lsr_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_SWEEP
   } state_type;

   state_type  state_ff, state_in;
   count_type  count_ff, count_in;
   item_type   top_ff, top_in;
   item_type   old_ff, old_in;
   item_type   new_ff, new_in;
   addr_type   widx_ff, widx_in;
   item_type   rdata_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   item_type   rsp_top_ff, rsp_top_in;
   count_type  rsp_fill_ff, rsp_fill_in;
   logic       rsp_empty_ff, rsp_empty_in;

   item_type   mem [DEPTH];
   logic       wr_en;
   addr_type   wr_addr;
   item_type   wr_data;
   addr_type   rd_addr;

   logic       accept;
   logic       done;
   status_type done_status;
   count_type  done_count;
   item_type   done_top;
   count_type  count_m1;
   count_type  count_m2;

   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign count_m1       = count_ff - count_type'(1);
   assign count_m2       = count_ff - count_type'(2);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      old_in      = old_ff;
      new_in      = new_ff;
      widx_in     = widx_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[ADDR_W-1:0];
      wr_data     = req_chan.value;
      rd_addr     = '0;
      done        = 1'b0;
      done_status = ST_OK;
      done_count  = count_ff;
      done_top    = top_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_chan.cmd)
                  CMD_PUSH: begin
                     done = 1'b1;
                     if (count_ff == count_type'(DEPTH)) begin
                        done_status = ST_FULL;
                     end else begin
                        wr_en      = 1'b1;
                        count_in   = count_ff + count_type'(1);
                        top_in     = req_chan.value;
                        done_count = count_ff + count_type'(1);
                        done_top   = req_chan.value;
                     end
                  end
                  CMD_POP: begin
                     if (count_ff == '0) begin
                        done        = 1'b1;
                        done_status = ST_EMPTY;
                     end else if (count_ff == count_type'(1)) begin
                        done       = 1'b1;
                        count_in   = '0;
                        top_in     = '0;
                        done_count = '0;
                     end else begin
                        rd_addr  = count_m2[ADDR_W-1:0];
                        count_in = count_m1;
                        state_in = S_POP;
                     end
                  end
                  CMD_TOP: begin
                     done = 1'b1;
                     if (count_ff == '0) begin
                        done_status = ST_EMPTY;
                     end
                  end
                  default: begin
                     if (count_ff == '0) begin
                        done = 1'b1;
                     end else begin
                        old_in   = req_chan.value;
                        new_in   = req_chan.new_value;
                        widx_in  = '0;
                        rd_addr  = '0;
                        state_in = S_SWEEP;
                        if (top_ff == req_chan.value) begin
                           top_in = req_chan.new_value;
                        end
                     end
                  end
               endcase
            end
         end
         S_POP: begin
            top_in   = rdata_ff;
            done     = 1'b1;
            done_top = rdata_ff;
            state_in = S_IDLE;
         end
         S_SWEEP: begin
            if (rdata_ff == old_ff) begin
               wr_en   = 1'b1;
               wr_addr = widx_ff;
               wr_data = new_ff;
            end
            rd_addr = widx_ff + addr_type'(1);
            widx_in = widx_ff + addr_type'(1);
            if (count_type'(widx_ff) == count_m1) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_empty_in  = rsp_empty_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = done_status;
         rsp_fill_in   = done_count;
         rsp_empty_in  = (done_count == '0);
         rsp_top_in    = (done_count == '0) ? '0 : done_top;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      old_ff        <= old_in;
      new_ff        <= new_in;
      widx_ff       <= widx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_fill_ff   <= rsp_fill_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.top_value  = rsp_top_ff;
   assign rsp_chan.fill_count = rsp_fill_ff;
   assign rsp_chan.is_empty   = rsp_empty_ff;

   `LSR_ASSERT_NEXT(a_push_full, clock, reset, accept && req_chan.cmd == CMD_PUSH && count_ff == count_type'(DEPTH), rsp_valid_ff && rsp_status_ff == ST_FULL && count_ff == count_type'(DEPTH))
   `LSR_ASSERT_NEXT(a_pop_empty, clock, reset, accept && req_chan.cmd == CMD_POP && count_ff == '0, rsp_valid_ff && rsp_status_ff == ST_EMPTY && rsp_empty_ff)
   `LSR_ASSERT_SAME(a_sweep_range, clock, reset, state_ff == S_SWEEP, count_type'(widx_ff) < count_ff)
   `LSR_ASSERT_SAME(a_empty_top, clock, reset, rsp_valid_ff && rsp_empty_ff, rsp_top_ff == '0 && rsp_fill_ff == '0)

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// LIFO stack with replace testbench
// Drives command beats into the stack with random gaps and result stalls.
// A local stack model predicts every result beat, and each accepted result is
// compared field by field against the oldest prediction. Directed commands
// cover empty, full and replace corner cases; random phases fill and drain
// the stack repeatedly.
// ---------------------------------------------------------------------------
module testbench;
   import lsr_pkg::*;

   typedef struct packed {
      status_type status;
      item_type   top_value;
      logic [4:0] fill_count;
      logic       is_empty;
   } stack_result_type;

   logic clock = 1'b0;
   logic reset;

   lsr_req_if req_bus ();
   lsr_rsp_if rsp_bus ();

   lifo_stack_with_replace_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   item_type         stack_mem [DEPTH];
   int               stack_fill;
   stack_result_type expected_results [$];
   int               mismatch_count;
   bit               no_idle;

   always #1 clock = ~clock;

   function automatic stack_result_type apply_command(cmd_type cmd, item_type v, item_type nv);
      stack_result_type res;
      res.status = ST_OK;
      case (cmd)
         CMD_PUSH: begin
            if (stack_fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               stack_mem[stack_fill] = v;
               stack_fill++;
            end
         end
         CMD_POP: begin
            if (stack_fill == 0) res.status = ST_EMPTY;
            else stack_fill--;
         end
         CMD_TOP: begin
            if (stack_fill == 0) res.status = ST_EMPTY;
         end
         default: begin
            for (int i = 0; i < stack_fill; i++) begin
               if (stack_mem[i] == v) stack_mem[i] = nv;
            end
         end
      endcase
      res.top_value  = (stack_fill > 0) ? stack_mem[stack_fill-1] : '0;
      res.fill_count = stack_fill[4:0];
      res.is_empty   = (stack_fill == 0);
      return res;
   endfunction

   function automatic int random_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic item_type pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 20) return '1;
      if (r < 40) return item_type'($urandom_range(1, 4));
      return item_type'($urandom);
   endfunction

   function automatic item_type pick_match_value();
      if (stack_fill > 0 && $urandom_range(0, 99) < 70) begin
         return stack_mem[$urandom_range(0, stack_fill - 1)];
      end
      return pick_value();
   endfunction

   function automatic cmd_type pick_cmd(int push_w, int pop_w, int top_w);
      int r;
      r = $urandom_range(0, 99);
      if (r < push_w) return CMD_PUSH;
      if (r < push_w + pop_w) return CMD_POP;
      if (r < push_w + pop_w + top_w) return CMD_TOP;
      return CMD_REPLACE;
   endfunction

   task automatic send_command(cmd_type cmd, item_type v, item_type nv);
      int gap;
      gap = no_idle ? 0 : random_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= cmd;
      req_bus.value     <= v;
      req_bus.new_value <= nv;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(apply_command(cmd, v, nv));
   endtask

   task automatic send_random(cmd_type cmd);
      item_type v;
      v = (cmd == CMD_REPLACE) ? pick_match_value() : pick_value();
      send_command(cmd, v, pick_value());
   endtask

   task automatic test_directed();
      send_command(CMD_TOP, item_type'($urandom), item_type'($urandom));
      send_command(CMD_POP, item_type'($urandom), item_type'($urandom));
      send_command(CMD_REPLACE, '0, '1);
      send_command(CMD_PUSH, '0, item_type'($urandom));
      send_command(CMD_PUSH, '1, item_type'($urandom));
      send_command(CMD_PUSH, '0, item_type'($urandom));
      send_command(CMD_REPLACE, '0, 32'h5A5A_A5A5);
      send_command(CMD_TOP, '0, '0);
      send_command(CMD_REPLACE, 32'h1234_5678, '0);
      send_command(CMD_REPLACE, '1, '0);
      while (stack_fill < DEPTH) send_command(CMD_PUSH, item_type'($urandom), '1);
      send_command(CMD_PUSH, 32'hDEAD_BEEF, '0);
      send_command(CMD_POP, '0, '0);
      send_command(CMD_TOP, '0, '0);
   endtask

   task automatic test_fill_drain();
      for (int round = 0; round < 4; round++) begin
         repeat (30) send_random(pick_cmd(70, 10, 10));
         repeat (25) send_random(pick_cmd(10, 65, 10));
      end
   endtask

   task automatic test_mixed();
      repeat (130) send_random(pick_cmd(35, 25, 10));
   endtask

   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (25) send_random(pick_cmd(60, 20, 10));
      repeat (25) send_random(pick_cmd(20, 50, 10));
      no_idle = 1'b0;
   endtask

   initial begin
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (no_idle) begin
            rsp_bus.ready <= 1'b1;
            @(posedge clock);
         end else begin
            stall = random_gap();
            if (stall > 0) begin
               rsp_bus.ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected result beat: status %0d top %h fill %0d empty %0b",
                        rsp_bus.status, rsp_bus.top_value, rsp_bus.fill_count,
                        rsp_bus.is_empty);
            end
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.status !== want.status || rsp_bus.top_value !== want.top_value ||
                rsp_bus.fill_count !== want.fill_count ||
                rsp_bus.is_empty !== want.is_empty) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Mismatch: expected status %0d top %h fill %0d empty %0b",
                           want.status, want.top_value, want.fill_count, want.is_empty);
                  $display("          actual   status %0d top %h fill %0d empty %0b",
                           rsp_bus.status, rsp_bus.top_value, rsp_bus.fill_count,
                           rsp_bus.is_empty);
               end
            end
         end
      end
   end

   initial begin
      #400000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      stack_fill        = 0;
      mismatch_count    = 0;
      no_idle           = 1'b0;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_PUSH;
      req_bus.value     <= '0;
      req_bus.new_value <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_fill_drain();
      test_mixed();
      test_back_to_back();

      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
